// File: hdl/mvt_pkg.sv
// shared types and constants for the 4x4 matrix vector transform
`timescale 1ns / 1ps

package mvt_pkg;

   localparam int Q_W         = 32;
   localparam int FRAC_W      = 16;
   localparam int DIM         = 4;
   localparam int ELEMS       = DIM * DIM;
   localparam int IDX_W       = 4;
   localparam int CMD_W       = 2;
   localparam int PROD_W      = 2 * Q_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int REQ_FIELD_W = IDX_W + Q_W + DIM * Q_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = DIM * Q_W;

   localparam logic [Q_W-1:0] Q_ONE   = 32'h0001_0000;
   localparam logic [Q_W-1:0] Q_MAX32 = 32'h7fff_ffff;
   localparam logic [Q_W-1:0] Q_MIN32 = 32'h8000_0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD      = 2'd0,
      CMD_TRANSFORM = 2'd1,
      CMD_TRANSPOSE = 2'd2,
      CMD_IDENTITY  = 2'd3
   } cmd_type;

endpackage

// File: hdl/mat4_vector_transform.sv
// top level: 4x4 q16.16 matrix store with a two-stage vector transform pipeline
`timescale 1ns / 1ps

// Holds a column-major 4x4 Q16.16 matrix (identity after reset) and takes one
// command per clock while not stalled: load element, transform vector,
// transpose, load identity. Matrix commands take effect at the transfer that
// accepts them and produce no output. A transform runs through two register
// stages, sixteen parallel 32x32 multipliers into a product register, then the
// row sums with floor shift and saturation into the output register, and one
// transform per clock is sustained while the output is not stalled. Backpressure
// on the output stalls the pipeline; the input is taken whenever the product
// stage is empty or moving on.
module mat4_vector_transform (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
   input  logic [mvt_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [mvt_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // res_x, res_y, res_z, res_w
   output logic [mvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // saturated
   output logic                           rsp_tuser
);
   import mvt_pkg::*;

   logic [Q_W-1:0]             matrix_ff [ELEMS];
   logic [Q_W-1:0]             matrix_in [ELEMS];
   logic signed [PROD_W-1:0]   prod_ff   [DIM][DIM];
   logic signed [PROD_W-1:0]   prod_in   [DIM][DIM];
   logic                       prod_valid_ff;
   logic                       rsp_valid_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_in;
   logic                       rsp_sat_ff;
   logic                       rsp_sat_in;
   logic                       out_move;
   logic                       prod_move;
   logic                       req_xfer;
   cmd_type                    cmd;
   logic [IDX_W-1:0]           elem_index;
   logic [Q_W-1:0]             elem_value;
   logic signed [Q_W-1:0]      vec       [DIM];

   assign cmd        = cmd_type'(req_tuser);
   assign elem_index = req_tdata[IDX_W-1:0];
   assign elem_value = req_tdata[IDX_W +: Q_W];

   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         vec[c] = req_tdata[IDX_W + Q_W + c * Q_W +: Q_W];
      end
   end

   assign out_move   = !rsp_valid_ff || rsp_tready;
   assign prod_move  = !prod_valid_ff || out_move;
   assign req_tready = prod_move;
   assign req_xfer   = req_tvalid && req_tready;

   // matrix update
   always_comb begin
      for (int i = 0; i < ELEMS; i++) begin
         matrix_in[i] = matrix_ff[i];
      end
      if (req_xfer) begin
         case (cmd)
            CMD_LOAD: begin
               matrix_in[elem_index] = elem_value;
            end
            CMD_TRANSPOSE: begin
               for (int c = 0; c < DIM; c++) begin
                  for (int r = 0; r < DIM; r++) begin
                     matrix_in[c * DIM + r] = matrix_ff[r * DIM + c];
                  end
               end
            end
            CMD_IDENTITY: begin
               for (int i = 0; i < ELEMS; i++) begin
                  matrix_in[i] = (i % (DIM + 1) == 0) ? Q_ONE : '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // stage one: row element times vector component
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            prod_in[r][c] = $signed(matrix_ff[c * DIM + r]) * vec[c];
         end
      end
   end

   // stage two: wide row sum, floor shift, saturate
   always_comb begin
      logic signed [SUM_W-1:0] sum;
      logic [SUM_W-FRAC_W-1:0] shifted;
      logic                    fits;
      rsp_sat_in  = 1'b0;
      rsp_data_in = '0;
      for (int r = 0; r < DIM; r++) begin
         sum = '0;
         for (int c = 0; c < DIM; c++) begin
            sum = sum + SUM_W'(prod_ff[r][c]);
         end
         shifted = sum[SUM_W-1:FRAC_W];
         fits    = (&shifted[SUM_W-FRAC_W-1:Q_W-1]) || !(|shifted[SUM_W-FRAC_W-1:Q_W-1]);
         if (fits) begin
            rsp_data_in[r * Q_W +: Q_W] = shifted[Q_W-1:0];
         end else begin
            rsp_data_in[r * Q_W +: Q_W] = shifted[SUM_W-FRAC_W-1] ? Q_MIN32 : Q_MAX32;
            rsp_sat_in                  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEMS; i++) begin
            matrix_ff[i] <= (i % (DIM + 1) == 0) ? Q_ONE : '0;
         end
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         matrix_ff <= matrix_in;
         if (prod_move) begin
            prod_valid_ff <= req_xfer && (cmd == CMD_TRANSFORM);
         end
         if (out_move) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_move && req_xfer && (cmd == CMD_TRANSFORM)) begin
         prod_ff <= prod_in;
      end
      if (out_move && prod_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// File: hdl/mvt_checker.sv
// port-level checks for the matrix vector transform, bound to the top level
`timescale 1ns / 1ps

module mvt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [mvt_pkg::CMD_W-1:0]      req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import mvt_pkg::*;

   logic req_transform;
   logic clamp_seen;

   assign req_transform = req_tvalid && req_tready && (req_tuser == CMD_TRANSFORM);

   always_comb begin
      clamp_seen = 1'b0;
      for (int r = 0; r < DIM; r++) begin
         if (rsp_tdata[r * Q_W +: Q_W] == Q_MAX32 || rsp_tdata[r * Q_W +: Q_W] == Q_MIN32) begin
            clamp_seen = 1'b1;
         end
      end
   end

   // stalled output holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled output transfer changed");

   // a fresh result traces back to an accepted transform via the product stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_transform, 2))
      else $error("output transfer without matching transform");

   // saturation flag implies a clamped component
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> clamp_seen)
      else $error("saturated set with no component at a bound");

   // output empty right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

   // no backpressure on input while the pipeline can drain
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind mat4_vector_transform mvt_checker u_mvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: dv/mvt_checker.sv
// transfer monitor, q16.16 transform predictor and result scoreboard for the matrix block
`timescale 1ns / 1ps

module mvt_scoreboard
   import mvt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   output int                    fail_count,
   output int                    pending_count,
   output int                    vectors_checked,
   output int                    clamped_checked
);

   typedef struct packed {
      logic                      sat;
      logic [DIM-1:0][Q_W-1:0]   comp;
   } vec_result_type;

   logic [Q_W-1:0] matrix_q [ELEMS];
   vec_result_type expected_vec_q [$];
   int             mismatches = 0;
   int             vec_count  = 0;
   int             clamp_count = 0;

   task automatic report(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic void load_unit_matrix();
      for (int i = 0; i < ELEMS; i++)
         matrix_q[i] = (i % (DIM + 1) == 0) ? Q_ONE : '0;
   endfunction

   function automatic void transpose_matrix();
      logic [Q_W-1:0] t;
      for (int r = 0; r < DIM; r++)
         for (int c = r + 1; c < DIM; c++) begin
            t                  = matrix_q[c*DIM + r];
            matrix_q[c*DIM + r] = matrix_q[r*DIM + c];
            matrix_q[r*DIM + c] = t;
         end
   endfunction

   // each row: exact 64-bit products summed at 66 bits, floor shift, clamp
   function automatic vec_result_type transform_vec(input logic [DIM-1:0][Q_W-1:0] vec);
      vec_result_type      r;
      longint              prod;
      logic signed [65:0]  wide;
      logic signed [65:0]  acc;
      logic signed [65:0]  shifted;
      r = '0;
      for (int row = 0; row < DIM; row++) begin
         acc = '0;
         for (int col = 0; col < DIM; col++) begin
            prod = longint'($signed(matrix_q[col*DIM + row])) * longint'($signed(vec[col]));
            wide = prod;
            acc  = acc + wide;
         end
         shifted = acc >>> FRAC_W;
         if (shifted > 66'sd2147483647) begin
            r.comp[row] = Q_MAX32;
            r.sat       = 1'b1;
         end else if (shifted < -66'sd2147483648) begin
            r.comp[row] = Q_MIN32;
            r.sat       = 1'b1;
         end else begin
            r.comp[row] = shifted[Q_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic check_vec(input vec_result_type got);
      vec_result_type want;
      if (expected_vec_q.size() == 0) begin
         report($sformatf("result %h sat %b with nothing outstanding", got.comp, got.sat));
      end else begin
         want = expected_vec_q.pop_front();
         for (int i = 0; i < DIM; i++)
            if (got.comp[i] !== want.comp[i])
               report($sformatf("row %0d want %h got %h", i, want.comp[i], got.comp[i]));
         if (got.sat !== want.sat)
            report($sformatf("saturated want %b got %b", want.sat, got.sat));
         vec_count++;
         if (want.sat)
            clamp_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_unit_matrix();
         expected_vec_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            case (cmd_type'(req_tuser))
               CMD_LOAD:      matrix_q[req_tdata[IDX_W-1:0]] = req_tdata[IDX_W +: Q_W];
               CMD_TRANSFORM: expected_vec_q.push_back(
                                 transform_vec(req_tdata[IDX_W+Q_W +: DIM*Q_W]));
               CMD_TRANSPOSE: transpose_matrix();
               CMD_IDENTITY:  load_unit_matrix();
               default:       report($sformatf("unknown command %b", req_tuser));
            endcase
         end
         if (rsp_tvalid && rsp_tready)
            check_vec({rsp_tuser, rsp_tdata});
      end
      fail_count      <= mismatches;
      pending_count   <= expected_vec_q.size();
      vectors_checked <= vec_count;
      clamped_checked <= clamp_count;
   end

endmodule

// File: dv/mat4_vector_transform_tb.sv
// testbench top: clock, reset, command stimulus, output backpressure and verdict
`timescale 1ns / 1ps

module mat4_vector_transform_tb;
   import mvt_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   int fail_count;
   int pending_count;
   int vectors_checked;
   int clamped_checked;
   int cmds_sent = 0;
   int burst_left = 0;

   mat4_vector_transform dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mvt_scoreboard u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .vectors_checked (vectors_checked),
      .clamped_checked (clamped_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // mix of full-range, small, whole-number and boundary q16.16 values
   function automatic logic [Q_W-1:0] rand_q();
      int t;
      t = 0;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom();
         3, 4, 5: begin
            t = $urandom_range(0, 1 << 20);
            return t - (1 << 19);
         end
         6: begin
            t = $urandom_range(0, 16);
            return ($urandom_range(0, 1) ? -t : t) << FRAC_W;
         end
         7: begin
            case ($urandom_range(0, 4))
               0: return Q_MAX32;
               1: return Q_MIN32;
               2: return '0;
               3: return 32'd1;
               default: return '1;
            endcase
         end
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [DIM-1:0][Q_W-1:0] rand_vec();
      logic [DIM-1:0][Q_W-1:0] v;
      for (int i = 0; i < DIM; i++)
         v[i] = rand_q();
      return v;
   endfunction

   task automatic send_cmd(input cmd_type cmd, input logic [IDX_W-1:0] idx,
                           input logic [Q_W-1:0] val, input logic [DIM-1:0][Q_W-1:0] vec);
      logic [REQ_DATA_W-1:0] d;
      int gap;
      d   = '0;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      d[IDX_W-1:0]               = idx;
      d[IDX_W +: Q_W]            = val;
      d[IDX_W+Q_W +: DIM*Q_W]    = vec;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      cmds_sent++;
   endtask

   task automatic send_load(input logic [IDX_W-1:0] idx, input logic [Q_W-1:0] val);
      send_cmd(CMD_LOAD, idx, val, rand_vec());
   endtask

   task automatic send_vec(input logic [DIM-1:0][Q_W-1:0] vec);
      send_cmd(CMD_TRANSFORM, IDX_W'($urandom()), $urandom(), vec);
   endtask

   // output backpressure: runs of always-ready, random, sparse and long stalls
   initial begin
      int mode;
      int span;
      rsp_tready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (k % 12 == 11);
            endcase
         end
      end
   end

   initial begin
      int scene;
      int n;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_LOAD;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity pass-through at the extremes
      send_vec({Q_MIN32, Q_MAX32, 32'hfffe_0000, Q_ONE});
      send_vec('0);
      // overflow in both directions, floor rounding of a negative fraction
      send_load(4'd0, Q_MAX32);
      send_load(4'd4, Q_MAX32);
      send_load(4'd1, Q_MIN32);
      send_load(4'd5, Q_MIN32);
      send_load(4'd3, Q_MIN32);
      send_load(4'd7, Q_MIN32);
      send_load(4'd11, Q_MIN32);
      send_load(4'd15, Q_MIN32);
      send_load(4'd10, 32'd1);
      send_vec({Q_MIN32, 32'hffff_ffff, Q_MAX32, Q_MAX32});
      send_vec({Q_MIN32, Q_MIN32, Q_MIN32, Q_MIN32});
      // transpose there and back, then back to unit matrix
      send_cmd(CMD_TRANSPOSE, IDX_W'($urandom()), $urandom(), rand_vec());
      send_vec(rand_vec());
      send_cmd(CMD_TRANSPOSE, IDX_W'($urandom()), $urandom(), rand_vec());
      send_vec({Q_MAX32, Q_MAX32, Q_MAX32, Q_MAX32});
      send_cmd(CMD_IDENTITY, IDX_W'($urandom()), $urandom(), rand_vec());
      send_vec(rand_vec());
      send_load(4'd15, 32'h0003_0000);
      send_load(4'd12, $urandom());
      send_vec(rand_vec());
      send_cmd(CMD_TRANSPOSE, IDX_W'($urandom()), $urandom(), rand_vec());
      send_vec(rand_vec());
      send_cmd(CMD_IDENTITY, IDX_W'($urandom()), $urandom(), rand_vec());

      while (cmds_sent < 830) begin
         scene = $urandom_range(0, 19);
         if (scene < 8) begin
            // full matrix followed by the four columns of a right-hand matrix
            for (int i = 0; i < ELEMS; i++)
               send_load(IDX_W'(i), rand_q());
            for (int i = 0; i < DIM; i++)
               send_vec(rand_vec());
         end else if (scene < 11) begin
            n = $urandom_range(1, 4);
            repeat (n) send_load(IDX_W'($urandom()), rand_q());
         end else if (scene < 17) begin
            n = $urandom_range(1, 12);
            repeat (n) send_vec(rand_vec());
         end else if (scene < 19) begin
            send_cmd(CMD_TRANSPOSE, IDX_W'($urandom()), $urandom(), rand_vec());
         end else begin
            send_cmd(CMD_IDENTITY, IDX_W'($urandom()), $urandom(), rand_vec());
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);

      $display("%0d commands sent across loads, transforms, transposes and identity reloads",
               cmds_sent);
      $display("%0d vector results checked, %0d of them clamped", vectors_checked,
               clamped_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
